// ===== rtl/tssr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the tile/sprite scanline renderer.
// No dependencies.
package tssr_pkg;

  localparam int LINE_WIDTH       = 160;
  localparam int SPRITE_COUNT     = 40;
  localparam int SPRITES_PER_LINE = 10;

  localparam int VRAM_SIZE  = 8192;
  localparam int TABLE_SIZE = SPRITE_COUNT * 4;
  localparam int GROUPS     = (LINE_WIDTH + 7) / 8;

  localparam int LBW  = $clog2(LINE_WIDTH);
  localparam int TW   = $clog2(TABLE_SIZE);
  localparam int SNW  = $clog2(SPRITE_COUNT + 1);
  localparam int SIW  = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int SLW  = $clog2(SPRITES_PER_LINE + 1);
  localparam int SLIW = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // input action codes
  localparam logic [1:0] ACT_VRAM   = 2'd0;
  localparam logic [1:0] ACT_SPRITE = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y        = 3'd1;
  localparam logic [2:0] REG_SCROLL_X        = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y        = 3'd3;
  localparam logic [2:0] REG_WINDOW_X        = 3'd4;
  localparam logic [2:0] REG_BG_PALETTE      = 3'd5;
  localparam logic [2:0] REG_OBJ_PALETTE_0   = 3'd6;
  localparam logic [2:0] REG_OBJ_PALETTE_1   = 3'd7;

  typedef enum logic [1:0] {
    K_VRAM,
    K_SPRITE,
    K_RENDER
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [7:0]  line;
    logic [1:0]  lcd_mode;
  } item_t;

  typedef struct packed {
    logic [7:0] display_control;
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
    logic [7:0] obj_palette_zero;
    logic [7:0] obj_palette_one;
  } cfg_t;

  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
    shade_of = pal[{idx, 1'b0} +: 2];
  endfunction

  // color index of column col (0 leftmost) of a tile row
  function automatic logic [1:0] tile_pix(input logic [7:0] lo, input logic [7:0] hi,
                                          input logic [2:0] col);
    logic [2:0] b;
    b = 3'd7 - col;
    tile_pix = {hi[b], lo[b]};
  endfunction

endpackage

// ===== rtl/tssr_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transfers, decodes the action and drops no-op items.
// Depends on tssr_pkg.
module tssr_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [12:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        line_i,
  input  logic [1:0]        lcd_mode_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output tssr_pkg::item_t   item_o
);
  import tssr_pkg::*;

  logic keep;

  always_comb begin
    keep = 1'b0;
    item_o.kind = K_VRAM;
    unique case (action_i)
      ACT_VRAM: begin
        keep = 1'b1;
        item_o.kind = K_VRAM;
      end
      ACT_SPRITE: begin
        // writes past the attribute table are ignored
        keep = (address_i < 13'(TABLE_SIZE));
        item_o.kind = K_SPRITE;
      end
      ACT_RENDER: begin
        keep = 1'b1;
        item_o.kind = K_RENDER;
      end
      default: keep = 1'b0;
    endcase
    item_o.address    = address_i;
    item_o.write_data = write_data_i;
    item_o.line       = line_i;
    item_o.lcd_mode   = lcd_mode_i;
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && keep;

endmodule

// ===== rtl/tssr_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of decoded items between front and back end.
// Depends on tssr_pkg.
module tssr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tssr_pkg::item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output tssr_pkg::item_t item_o,
  input  logic            pop_i
);
  import tssr_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPW-1:0]     wp_q, rp_q;
  logic [QPW:0]       cnt_q;
  logic               do_pop;

  assign ready_o = (cnt_q != (QPW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPW+1)'(push_i) - (QPW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/tssr_back.sv =====
`timescale 1ns / 1ps
// Back end: video/attribute memories, line buffer and the render sequencer.
// Depends on tssr_pkg.
module tssr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tssr_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  tssr_pkg::item_t q_item_i,
  output logic            q_pop_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [4:0]      group_index_o,
  output logic [15:0]     shades_o,
  output logic            last_group_o
);
  import tssr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_BG   = 3'd3;
  localparam logic [2:0] ST_SPA  = 3'd4;
  localparam logic [2:0] ST_SPT  = 3'd5;
  localparam logic [2:0] ST_SPP  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // memories
  logic [7:0] vram_mem [VRAM_SIZE];
  logic [7:0] spr_mem  [TABLE_SIZE];
  logic [3:0] lb_mem   [LINE_WIDTH];   // {color index, shade}

  logic           vram_we, spr_we, lb_we;
  logic [12:0]    vram_ra;
  logic [TW-1:0]  spr_ra;
  logic [LBW-1:0] lb_ra, lb_wa;
  logic [3:0]     lb_wd;
  logic [7:0]     vram_rd_q, spr_rd_q;
  logic [3:0]     lb_rd_q;

  always_ff @(posedge clk_i) begin
    if (vram_we) vram_mem[q_item_i.address] <= q_item_i.write_data;
    vram_rd_q <= vram_mem[vram_ra];
  end

  always_ff @(posedge clk_i) begin
    if (spr_we) spr_mem[TW'(q_item_i.address)] <= q_item_i.write_data;
    spr_rd_q <= spr_mem[spr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) lb_mem[lb_wa] <= lb_wd;
    lb_rd_q <= lb_mem[lb_ra];
  end

  // sequencer state
  logic [2:0]      state_q, state_d;
  logic [7:0]      line_q, line_d;
  logic [1:0]      mode_q, mode_d;
  logic [SNW-1:0]  n_q, n_d;
  logic            chk_v_q, chk_v_d;
  logic [SIW-1:0]  chk_n_q, chk_n_d;
  logic [SLW-1:0]  cnt_q, cnt_d;
  logic [SIW-1:0]  sel_q [SPRITES_PER_LINE];
  logic [SIW-1:0]  sel_d [SPRITES_PER_LINE];
  logic [7:0]      wlc_q, wlc_d, wy_q, wy_d;
  logic            win_q, win_d;
  logic [LBW-1:0]  x_q, x_d;
  logic [1:0]      step_q, step_d;
  logic [2:0]      col_q, col_d, trow_q, trow_d;
  logic [12:0]     tra_q, tra_d;
  logic [7:0]      lo_q, lo_d, hi_q, hi_d;
  logic [SLIW-1:0] s_q, s_d;
  logic [2:0]      sub_q, sub_d;
  logic [7:0]      sy_q, sy_d, sxp_q, sxp_d, stile_q, stile_d, sattr_q, sattr_d;
  logic [2:0]      k_q, k_d;
  logic            ph_q, ph_d;
  logic [LBW-1:0]  psx_q, psx_d;
  logic [1:0]      pshade_q, pshade_d;
  logic [4:0]      og_q, og_d;
  logic [3:0]      ok_q, ok_d;
  logic            pv_q, pv_d;
  logic [15:0]     asm_q, asm_d;
  logic            ov_q, ov_d;
  logic [4:0]      ogi_q, ogi_d;
  logic [15:0]     osh_q, osh_d;
  logic            olast_q, olast_d;

  // scratch
  logic        disp, bgen, spren, h16, adv, inwin, msel;
  logic [9:0]  ly, yb, hv;
  logic [8:0]  wp, t9, sx9, pos;
  logic [7:0]  px, py, wy, tile;
  logic [4:0]  mrow, mcol;
  logic [3:0]  row;
  logic [2:0]  col;
  logic [1:0]  idx, shade;
  logic [12:0] ta;
  logic        wdraw;

  assign disp  = cfg_i.display_control[7];
  assign bgen  = cfg_i.display_control[0];
  assign spren = cfg_i.display_control[1];
  assign h16   = cfg_i.display_control[2];

  always_comb begin
    state_d = state_q;  line_d = line_q;   mode_d = mode_q;
    n_d = n_q;  chk_v_d = chk_v_q;  chk_n_d = chk_n_q;  cnt_d = cnt_q;
    sel_d = sel_q;
    wlc_d = wlc_q;  wy_d = wy_q;  win_d = win_q;
    x_d = x_q;  step_d = step_q;  col_d = col_q;  trow_d = trow_q;  tra_d = tra_q;
    lo_d = lo_q;  hi_d = hi_q;  s_d = s_q;  sub_d = sub_q;
    sy_d = sy_q;  sxp_d = sxp_q;  stile_d = stile_q;  sattr_d = sattr_q;
    k_d = k_q;  ph_d = ph_q;  psx_d = psx_q;  pshade_d = pshade_q;
    og_d = og_q;  ok_d = ok_q;  pv_d = pv_q;  asm_d = asm_q;
    ogi_d = ogi_q;  osh_d = osh_q;  olast_d = olast_q;
    ov_d = ov_q && !out_ready_i;

    q_pop_o = 1'b0;  vram_we = 1'b0;  spr_we = 1'b0;  lb_we = 1'b0;
    vram_ra = '0;  spr_ra = '0;  lb_ra = '0;  lb_wa = '0;  lb_wd = '0;

    adv = 1'b0;  inwin = 1'b0;  msel = 1'b0;  wdraw = 1'b0;
    ly = '0;  yb = '0;  hv = '0;  wp = '0;  t9 = '0;  sx9 = '0;  pos = '0;
    px = '0;  py = '0;  wy = '0;  tile = '0;  mrow = '0;  mcol = '0;
    row = '0;  col = '0;  idx = '0;  shade = '0;  ta = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.kind)
            K_VRAM:   vram_we = 1'b1;
            K_SPRITE: spr_we = 1'b1;
            K_RENDER: begin
              line_d  = q_item_i.line;
              mode_d  = q_item_i.lcd_mode;
              n_d     = '0;
              chk_v_d = 1'b0;
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      // attribute scan: the y byte of each entry is read in the cycle before its check
      ST_SCAN: begin
        if (chk_v_q) begin
          ly = 10'(line_q) + 10'd16;
          yb = 10'(spr_rd_q);
          hv = h16 ? 10'd16 : 10'd8;
          if (ly >= yb && ly < yb + hv && cnt_q < SLW'(SPRITES_PER_LINE)) begin
            sel_d[cnt_q[SLIW-1:0]] = chk_n_q;
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (n_q < SNW'(SPRITE_COUNT)) begin
          spr_ra  = TW'({n_q, 2'b00});
          chk_v_d = 1'b1;
          chk_n_d = SIW'(n_q);
          n_d     = n_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        wy = (line_q == 8'd0 && mode_q != 2'd1) ? 8'd0 : wlc_q;
        wdraw = disp && bgen && cfg_i.display_control[5] && line_q >= cfg_i.window_y &&
                (9'(cfg_i.window_x) < 9'(LINE_WIDTH + 7));
        if (disp && bgen) begin
          wy_d  = wy;
          wlc_d = wdraw ? wy + 8'd1 : wy;
        end
        win_d   = wdraw;
        x_d     = '0;
        step_d  = 2'd0;
        state_d = ST_BG;
      end

      // per pixel: map read, low plane read, high plane read, write
      ST_BG: begin
        unique case (step_q)
          2'd0: begin
            inwin = win_q && (9'(x_q) + 9'd7 >= 9'(cfg_i.window_x));
            if (inwin) begin
              wp   = 9'(x_q) + 9'd7 - 9'(cfg_i.window_x);
              mrow = wy_q[7:3];
              mcol = wp[7:3];
              col  = wp[2:0];
              trow_d = wy_q[2:0];
              msel = cfg_i.display_control[6];
            end else begin
              px   = 8'(9'(x_q) + 9'(cfg_i.scroll_x));
              py   = line_q + cfg_i.scroll_y;
              mrow = py[7:3];
              mcol = px[7:3];
              col  = px[2:0];
              trow_d = py[2:0];
              msel = cfg_i.display_control[3];
            end
            col_d   = col;
            vram_ra = {2'b11, msel, mrow, mcol};
            step_d  = 2'd1;
          end
          2'd1: begin
            tile = vram_rd_q;
            if (cfg_i.display_control[4]) ta = {1'b0, tile, trow_q, 1'b0};
            else ta = 13'h1000 + {tile[7], tile, 4'b0000} + {9'd0, trow_q, 1'b0};
            tra_d   = ta;
            vram_ra = ta;
            step_d  = 2'd2;
          end
          2'd2: begin
            lo_d    = vram_rd_q;
            vram_ra = tra_q + 13'd1;
            step_d  = 2'd3;
          end
          default: begin
            idx = tile_pix(lo_q, vram_rd_q, col_q);
            if (!disp) shade = 2'd0;
            else if (bgen) shade = shade_of(cfg_i.bg_palette, idx);
            else shade = cfg_i.bg_palette[1:0];
            lb_we  = 1'b1;
            lb_wa  = x_q;
            lb_wd  = {bgen ? idx : 2'd0, shade};
            step_d = 2'd0;
            if (x_q == LBW'(LINE_WIDTH - 1)) begin
              if (disp && spren && cnt_q != '0) begin
                s_d     = SLIW'(cnt_q - 1'b1);
                sub_d   = 3'd0;
                state_d = ST_SPA;
              end else begin
                og_d    = '0;
                ok_d    = '0;
                state_d = ST_OUT;
              end
            end else begin
              x_d = x_q + 1'b1;
            end
          end
        endcase
      end

      // fetch the four attribute bytes of the selected entry
      ST_SPA: begin
        spr_ra = TW'({sel_q[s_q], sub_q[1:0]});
        unique case (sub_q)
          3'd1:    sy_d = spr_rd_q;
          3'd2:    sxp_d = spr_rd_q;
          3'd3:    stile_d = spr_rd_q;
          3'd4:    sattr_d = spr_rd_q;
          default: ;
        endcase
        if (sub_q == 3'd4) begin
          step_d  = 2'd0;
          state_d = ST_SPT;
        end else begin
          sub_d = sub_q + 3'd1;
        end
      end

      ST_SPT: begin
        unique case (step_q)
          2'd0: begin
            row  = 4'(line_q - sy_q);
            tile = h16 ? {stile_q[7:1], 1'b0} : stile_q;
            if (sattr_q[6]) row = row ^ (h16 ? 4'd15 : 4'd7);
            ta = 13'({tile, 4'b0000}) + 13'({row, 1'b0});
            tra_d   = ta;
            vram_ra = ta;
            step_d  = 2'd1;
          end
          2'd1: begin
            lo_d    = vram_rd_q;
            vram_ra = tra_q + 13'd1;
            step_d  = 2'd2;
          end
          default: begin
            hi_d    = vram_rd_q;
            k_d     = 3'd0;
            ph_d    = 1'b0;
            step_d  = 2'd0;
            state_d = ST_SPP;
          end
        endcase
      end

      // per sprite pixel: read the line buffer entry, then merge
      ST_SPP: begin
        if (!ph_q) begin
          t9  = 9'(sxp_q) + 9'(k_q);
          sx9 = t9 - 9'd8;
          col = sattr_q[5] ? 3'd7 - k_q : k_q;
          idx = tile_pix(lo_q, hi_q, col);
          if (t9 >= 9'd8 && sx9 < 9'(LINE_WIDTH) && idx != 2'd0) begin
            lb_ra    = LBW'(sx9);
            psx_d    = LBW'(sx9);
            pshade_d = shade_of(sattr_q[4] ? cfg_i.obj_palette_one : cfg_i.obj_palette_zero,
                                idx);
            ph_d     = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end else begin
          // behind-background: only over color index 0
          if (!(sattr_q[7] && lb_rd_q[3:2] != 2'd0)) begin
            lb_we = 1'b1;
            lb_wa = psx_q;
            lb_wd = {lb_rd_q[3:2], pshade_q};
          end
          ph_d = 1'b0;
          adv  = 1'b1;
        end
        if (adv) begin
          if (k_q == 3'd7) begin
            if (s_q == '0) begin
              og_d    = '0;
              ok_d    = '0;
              state_d = ST_OUT;
            end else begin
              s_d     = s_q - 1'b1;
              sub_d   = 3'd0;
              state_d = ST_SPA;
            end
          end else begin
            k_d = k_q + 3'd1;
          end
        end
      end

      // gather eight pixels, then hand the group to the output register
      default: begin
        if (ok_q != 4'd8) begin
          pos   = {1'b0, og_q, ok_q[2:0]};
          lb_ra = LBW'(pos);
          pv_d  = (pos < 9'(LINE_WIDTH));
        end else begin
          // keep the last pixel on the read port while the output is stalled
          pos   = {1'b0, og_q, 3'd7};
          lb_ra = LBW'(pos);
        end
        if (ok_q != 4'd0) begin
          asm_d[{3'(ok_q - 4'd1), 1'b0} +: 2] = pv_q ? lb_rd_q[1:0] : 2'd0;
        end
        if (ok_q != 4'd8) begin
          ok_d = ok_q + 4'd1;
        end else if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ogi_d   = og_q;
          osh_d   = asm_d;
          olast_d = (og_q == 5'(GROUPS - 1));
          if (og_q == 5'(GROUPS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            og_d = og_q + 5'd1;
            ok_d = 4'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wlc_q   <= '0;
      ov_q    <= 1'b0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wlc_q   <= wlc_d;
      ov_q    <= ov_d;
      chk_v_q <= chk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;  mode_q <= mode_d;  n_q <= n_d;  chk_n_q <= chk_n_d;
    cnt_q <= cnt_d;  sel_q <= sel_d;  wy_q <= wy_d;  win_q <= win_d;
    x_q <= x_d;  step_q <= step_d;  col_q <= col_d;  trow_q <= trow_d;
    tra_q <= tra_d;  lo_q <= lo_d;  hi_q <= hi_d;  s_q <= s_d;  sub_q <= sub_d;
    sy_q <= sy_d;  sxp_q <= sxp_d;  stile_q <= stile_d;  sattr_q <= sattr_d;
    k_q <= k_d;  ph_q <= ph_d;  psx_q <= psx_d;  pshade_q <= pshade_d;
    og_q <= og_d;  ok_q <= ok_d;  pv_q <= pv_d;  asm_q <= asm_d;
    ogi_q <= ogi_d;  osh_q <= osh_d;  olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign group_index_o = ogi_q;
  assign shades_o      = osh_q;
  assign last_group_o  = olast_q;

endmodule

// ===== rtl/tile_sprite_scanline_renderer.sv =====
`timescale 1ns / 1ps
// Tile map / sprite scanline renderer, 160 pixels, 20 groups of 8 shades.
// A render runs an attribute scan, then the background pixel by pixel (one video
// RAM port), then each selected sprite, then the output groups of eight pixels.
// Reset clears control state, the window line counter and the registers;
// video and attribute memory and the line buffer are undefined until written.
module tile_sprite_scanline_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [12:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  line_i,
  input  logic [1:0]  lcd_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  group_index_o,
  output logic [15:0] shades_o,
  output logic        last_group_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tssr_pkg::*;

  cfg_t  cfg_q;
  item_t f_item, q_item;
  logic  f_push, q_ready, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DISPLAY_CONTROL: cfg_q.display_control  <= cfg_data_i;
        REG_SCROLL_Y:        cfg_q.scroll_y         <= cfg_data_i;
        REG_SCROLL_X:        cfg_q.scroll_x         <= cfg_data_i;
        REG_WINDOW_Y:        cfg_q.window_y         <= cfg_data_i;
        REG_WINDOW_X:        cfg_q.window_x         <= cfg_data_i;
        REG_BG_PALETTE:      cfg_q.bg_palette       <= cfg_data_i;
        REG_OBJ_PALETTE_0:   cfg_q.obj_palette_zero <= cfg_data_i;
        REG_OBJ_PALETTE_1:   cfg_q.obj_palette_one  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tssr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .line_i       (line_i),
    .lcd_mode_i   (lcd_mode_i),
    .q_ready_i    (q_ready),
    .push_o       (f_push),
    .item_o       (f_item)
  );

  tssr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  tssr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .group_index_o (group_index_o),
    .shades_o      (shades_o),
    .last_group_o  (last_group_o)
  );

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_group_o == (group_index_o == 5'(GROUPS - 1))))
    else $error("last_group flag does not match group index");

  a_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (group_index_o < 5'(GROUPS)))
    else $error("group index out of range");

  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_group_o) ##1 out_valid_o |->
      (group_index_o == $past(group_index_o) + 5'd1))
    else $error("groups out of order");

endmodule
